>>> design/slc_pkg.sv
`default_nettype none

package slc_pkg;

    // Sequencer states of the clustering core.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_ROW_A,
        ST_ROW_W,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_UPD,
        ST_UPD_END
    } slc_state_t;

    // Fixed widths of the result fields and the configuration word.
    localparam int unsigned NAME_OUT_W = 6;
    localparam int unsigned DIST_OUT_W = 16;
    localparam int unsigned CFG_W      = 7;

endpackage

`default_nettype wire

>>> design/slc_ram.sv
`default_nettype none

module slc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/slc_best.sv
`default_nettype none

// Running minimum of (distance, earlier position, later position) over the
// matrix entries of one merge round.
module slc_best #(
    parameter int unsigned PW = 6,
    parameter int unsigned DW = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          clear,
    input  wire logic          cmp_en,
    input  wire logic [DW-1:0] d,
    input  wire logic [PW-1:0] a,
    input  wire logic [PW-1:0] b,
    input  wire logic [PW-1:0] name_a,
    input  wire logic [PW-1:0] name_b,
    output logic      [DW-1:0] best_d,
    output logic      [PW-1:0] best_a,
    output logic      [PW-1:0] best_b,
    output logic      [PW-1:0] best_name_a,
    output logic      [PW-1:0] best_name_b
);

    logic          have_reg;
    logic [DW-1:0] d_reg;
    logic [PW-1:0] a_reg, b_reg, na_reg, nb_reg;
    logic          take;

    always_comb begin
        take = 1'b0;
        if (cmp_en && (a < b)) begin
            if (!have_reg || (d < d_reg)) begin
                take = 1'b1;
            end else if (d == d_reg) begin
                take = (a < a_reg) || ((a == a_reg) && (b < b_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (clear) begin
            have_reg <= 1'b0;
        end else if (take) begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            d_reg  <= d;
            a_reg  <= a;
            b_reg  <= b;
            na_reg <= name_a;
            nb_reg <= name_b;
        end
    end

    assign best_d      = d_reg;
    assign best_a      = a_reg;
    assign best_b      = b_reg;
    assign best_name_a = na_reg;
    assign best_name_b = nb_reg;

endmodule

`default_nettype wire

>>> design/single_linkage_clustering_core.sv
// Load: one matrix entry is taken per cycle, n*n transfers for n points.
// Merge: each of the n-1 rounds scans all n*n entries through the one shared compare unit,
// plus any wait for the result channel.
// No input is taken during the merge phase.
// The first record follows the init pass over the point store and the first round's scan.
// Reset (aresetn low, synchronous) sets the point count to the maximum and restarts loading.
`default_nettype none

module single_linkage_clustering_core #(
    parameter int unsigned MAX_POINTS = 64,
    parameter int unsigned DIST_WIDTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [slc_pkg::CFG_W-1:0]      cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [15:0]                    s_distance_entry,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [slc_pkg::NAME_OUT_W-1:0]      m_first_cluster,
    output logic [slc_pkg::NAME_OUT_W-1:0]      m_second_cluster,
    output logic [slc_pkg::DIST_OUT_W-1:0]      m_merge_distance,
    output logic                                m_last_merge
);

    localparam int unsigned PW = $clog2(MAX_POINTS);
    localparam int unsigned NW = $clog2(MAX_POINTS + 1);
    localparam int unsigned AW = $clog2(MAX_POINTS * MAX_POINTS);
    localparam int unsigned TW = 2 * PW;

    slc_pkg::slc_state_t state_reg, state_next;

    // Effective point count, clipped when the register is written.
    logic [NW-1:0] n_reg;
    logic [NW-1:0] n_next;
    logic [PW-1:0] n_last;

    // p1 and p2 walk rows and columns, both while loading and while scanning.
    logic [PW-1:0] p1_reg, p2_reg, idx_reg;
    logic [NW-1:0] cnt_reg;
    logic [PW-1:0] a_pos_reg, a_name_reg;
    logic          pipe_v_reg;
    logic          up_v_reg;
    logic [PW-1:0] up_idx_reg;

    logic          accept;
    logic          out_free;

    // Matrix store.
    logic                  mat_we;
    logic [AW-1:0]         mat_waddr, mat_raddr;
    logic [DIST_WIDTH-1:0] mat_rdata;

    // Per-point store: cluster name in the upper half, list position in the lower.
    logic          pt_we;
    logic [PW-1:0] pt_waddr, pt_raddr;
    logic [TW-1:0] pt_wdata, pt_rdata;
    logic [PW-1:0] rd_pos, rd_name;

    logic [DIST_WIDTH-1:0] best_d;
    logic [PW-1:0]         best_a, best_b, best_name_a, best_name_b;
    logic                  best_clear;

    logic [PW-1:0] upd_pos, upd_name;

    logic                            m_valid_reg;
    logic [slc_pkg::NAME_OUT_W-1:0]  m_first_reg, m_second_reg;
    logic [slc_pkg::DIST_OUT_W-1:0]  m_dist_reg;
    logic                            m_last_reg;

    assign n_last   = PW'(n_reg - NW'(1));
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_pos   = pt_rdata[PW-1:0];
    assign rd_name  = pt_rdata[TW-1:PW];

    always_comb begin
        if (cfg_wr_data == '0) begin
            n_next = NW'(1);
        end else if (32'(cfg_wr_data) > MAX_POINTS) begin
            n_next = NW'(MAX_POINTS);
        end else begin
            n_next = NW'(cfg_wr_data);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            slc_pkg::ST_LOAD: begin
                if (!cfg_wr_en && accept && (p1_reg == n_last) && (p2_reg == n_last)) begin
                    state_next = slc_pkg::ST_INIT;
                end
            end
            slc_pkg::ST_INIT: begin
                if (idx_reg == n_last) begin
                    state_next = (n_reg == NW'(1)) ? slc_pkg::ST_LOAD : slc_pkg::ST_ROW_A;
                end
            end
            slc_pkg::ST_ROW_A: state_next = slc_pkg::ST_ROW_W;
            slc_pkg::ST_ROW_W: state_next = slc_pkg::ST_SCAN;
            slc_pkg::ST_SCAN: begin
                if (p2_reg == n_last) begin
                    state_next = (p1_reg == n_last) ? slc_pkg::ST_DRAIN : slc_pkg::ST_ROW_A;
                end
            end
            slc_pkg::ST_DRAIN: state_next = slc_pkg::ST_EMIT;
            slc_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = slc_pkg::ST_UPD;
                end
            end
            slc_pkg::ST_UPD: begin
                if (idx_reg == n_last) begin
                    state_next = slc_pkg::ST_UPD_END;
                end
            end
            slc_pkg::ST_UPD_END: begin
                state_next = (cnt_reg == NW'(2)) ? slc_pkg::ST_LOAD : slc_pkg::ST_ROW_A;
            end
            default: state_next = slc_pkg::ST_LOAD;
        endcase
    end

    // Memory port, input ready and compare clear selection per state.
    always_comb begin
        s_ready    = 1'b0;
        mat_we     = 1'b0;
        pt_raddr   = idx_reg;
        best_clear = 1'b0;
        case (state_reg)
            slc_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                mat_we  = accept && !cfg_wr_en;
            end
            slc_pkg::ST_INIT:    best_clear = 1'b1;
            slc_pkg::ST_ROW_A:   pt_raddr   = p1_reg;
            slc_pkg::ST_SCAN:    pt_raddr   = p2_reg;
            slc_pkg::ST_UPD_END: best_clear = 1'b1;
            default: pt_raddr = idx_reg;
        endcase
    end

    assign mat_waddr = AW'(32'(p1_reg) * MAX_POINTS + 32'(p2_reg));
    assign mat_raddr = mat_waddr;

    // Position and name of a point after the winning pair leaves the list and
    // their union is appended at its end.
    always_comb begin
        if ((rd_pos == best_a) || (rd_pos == best_b)) begin
            upd_pos = PW'(cnt_reg - NW'(2));
        end else begin
            upd_pos = rd_pos - PW'(rd_pos > best_a) - PW'(rd_pos > best_b);
        end
        upd_name = (rd_pos == best_b) ? best_name_a : rd_name;
    end

    always_comb begin
        if (state_reg == slc_pkg::ST_INIT) begin
            pt_we    = 1'b1;
            pt_waddr = idx_reg;
            pt_wdata = {idx_reg, idx_reg};
        end else begin
            pt_we    = up_v_reg;
            pt_waddr = up_idx_reg;
            pt_wdata = {upd_name, upd_pos};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= slc_pkg::ST_LOAD;
            n_reg     <= NW'(MAX_POINTS);
            p1_reg    <= '0;
            p2_reg    <= '0;
            idx_reg   <= '0;
            cnt_reg   <= NW'(MAX_POINTS);
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                n_reg <= n_next;
            end
            case (state_reg)
                slc_pkg::ST_LOAD: begin
                    if (cfg_wr_en) begin
                        p1_reg <= '0;
                        p2_reg <= '0;
                    end else if (accept) begin
                        if (p2_reg == n_last) begin
                            p2_reg <= '0;
                            p1_reg <= (p1_reg == n_last) ? '0 : p1_reg + PW'(1);
                        end else begin
                            p2_reg <= p2_reg + PW'(1);
                        end
                        idx_reg <= '0;
                    end
                end
                slc_pkg::ST_INIT: begin
                    idx_reg <= (idx_reg == n_last) ? '0 : idx_reg + PW'(1);
                    p1_reg  <= '0;
                    cnt_reg <= n_reg;
                end
                slc_pkg::ST_ROW_W: p2_reg <= '0;
                slc_pkg::ST_SCAN: begin
                    p2_reg <= p2_reg + PW'(1);
                    if (p2_reg == n_last) begin
                        p1_reg <= (p1_reg == n_last) ? '0 : p1_reg + PW'(1);
                    end
                end
                slc_pkg::ST_EMIT: idx_reg <= '0;
                slc_pkg::ST_UPD: begin
                    idx_reg <= (idx_reg == n_last) ? '0 : idx_reg + PW'(1);
                end
                slc_pkg::ST_UPD_END: begin
                    cnt_reg <= cnt_reg - NW'(1);
                    p1_reg  <= '0;
                    p2_reg  <= '0;
                end
                default: idx_reg <= idx_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_v_reg <= 1'b0;
            up_v_reg   <= 1'b0;
        end else begin
            pipe_v_reg <= (state_reg == slc_pkg::ST_SCAN);
            up_v_reg   <= (state_reg == slc_pkg::ST_UPD);
        end
    end

    always_ff @(posedge aclk) begin
        up_idx_reg <= idx_reg;
        if (state_reg == slc_pkg::ST_ROW_W) begin
            a_pos_reg  <= rd_pos;
            a_name_reg <= rd_name;
        end
    end

    // Output register: a record waits here while the sequencer moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == slc_pkg::ST_EMIT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == slc_pkg::ST_EMIT) && out_free) begin
            m_first_reg  <= slc_pkg::NAME_OUT_W'(best_name_a);
            m_second_reg <= slc_pkg::NAME_OUT_W'(best_name_b);
            m_dist_reg   <= slc_pkg::DIST_OUT_W'(best_d);
            m_last_reg   <= (cnt_reg == NW'(2));
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_first_cluster  = m_first_reg;
    assign m_second_cluster = m_second_reg;
    assign m_merge_distance = m_dist_reg;
    assign m_last_merge     = m_last_reg;

    slc_ram #(
        .WIDTH (DIST_WIDTH),
        .DEPTH (MAX_POINTS * MAX_POINTS)
    ) u_matrix (
        .aclk  (aclk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (DIST_WIDTH'(s_distance_entry)),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    slc_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    // The shared compare unit sees one entry per cycle while scanning, in the cycle after its read.
    slc_best #(
        .PW (PW),
        .DW (DIST_WIDTH)
    ) u_best (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (best_clear),
        .cmp_en      (pipe_v_reg),
        .d           (mat_rdata),
        .a           (a_pos_reg),
        .b           (rd_pos),
        .name_a      (a_name_reg),
        .name_b      (rd_name),
        .best_d      (best_d),
        .best_a      (best_a),
        .best_b      (best_b),
        .best_name_a (best_name_a),
        .best_name_b (best_name_b)
    );

endmodule

`default_nettype wire

>>> design/slc_checker.sv
`default_nettype none

module slc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [5:0]  m_first_cluster,
    input wire logic [5:0]  m_second_cluster,
    input wire logic [15:0] m_merge_distance,
    input wire logic        m_last_merge
);

    // A pending record holds until its transfer.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_first_cluster)
            && $stable(m_second_cluster) && $stable(m_merge_distance))
        else $error("record changed while stalled");

    // While records other than the last are pending, no matrix entry is taken.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_merge |-> !s_ready)
        else $error("input ready during merge phase");

    // After a record that is not the last, the merge phase continues.
    a_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_merge |=> !s_ready)
        else $error("merge phase ended early");

endmodule

bind single_linkage_clustering_core slc_checker u_slc_checker (.*);

`default_nettype wire
